### rtl/core/olst_pkg.sv
// Shared types and codes for the ordered list engine.
// Depends on nothing; every other file of the block but olst_ram imports it.
package olst_pkg;

    localparam int CMD_W = 4;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int ST_W  = 3;
    localparam int IDX_W = 6;
    // position compare width: one bit over the position field
    localparam int CMP_W = POS_W + 1;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REM_VAL = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REM_AT  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SIZE    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DUMP    = 4'd8;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] element;
        logic [IDX_W-1:0]        index;
        logic                    last;
    } olst_word_t;

endpackage

### rtl/core/olst_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module olst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/olst_out_reg.sv
// Result word register between the sequencer and the result channel.
// Depends on olst_pkg for the result word type.
module olst_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  olst_pkg::olst_word_t          word,
    output logic                          slot_free,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [olst_pkg::ST_W-1:0]     status,
    output logic signed [olst_pkg::VAL_W-1:0] element,
    output logic [olst_pkg::IDX_W-1:0]    index,
    output logic                          last
);
    import olst_pkg::*;

    logic       valid_reg;
    olst_word_t word_reg;

    assign slot_free = !valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg <= word;
        end
    end

    assign res_valid = valid_reg;
    assign status    = word_reg.status;
    assign element   = word_reg.element;
    assign index     = word_reg.index;
    assign last      = word_reg.last;

endmodule

### rtl/core/olst_ctrl.sv
// Command sequencer: decodes a command, walks the element RAM one entry per
// read/write pair, and hands result words to the output register.
// Depends on olst_pkg.
module olst_ctrl #(
    parameter int CAPACITY = 32,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [olst_pkg::CMD_W-1:0]    command,
    input  logic signed [olst_pkg::VAL_W-1:0] value,
    input  logic [olst_pkg::POS_W-1:0]    position,
    output logic                          push,
    output olst_pkg::olst_word_t          word,
    input  logic                          slot_free,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic [olst_pkg::VAL_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [AW-1:0]                 ram_raddr,
    input  logic [olst_pkg::VAL_W-1:0]    ram_rdata
);
    import olst_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_SHF_RD   = 4'd3;
    localparam logic [3:0] S_SHF_WR   = 4'd4;
    localparam logic [3:0] S_INS_WR   = 4'd5;
    localparam logic [3:0] S_DEL_RD   = 4'd6;
    localparam logic [3:0] S_DEL_WR   = 4'd7;
    localparam logic [3:0] S_DMP_RD   = 4'd8;
    localparam logic [3:0] S_DMP_OUT  = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0] elem_reg, elem_next;
    logic [IDX_W-1:0] index_reg, index_next;

    logic [CMP_W-1:0] cnt_cmp;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] ins_pos;
    logic             ptr_at_end;

    assign cnt_cmp    = CMP_W'(cnt_reg);
    assign pos_cmp    = CMP_W'(position);
    assign ptr_at_end = (CW'(ptr_reg) + CW'(1)) == cnt_reg;
    assign cmd_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        case (command)
            CMD_APPEND:  ins_pos = cnt_cmp;
            CMD_PREPEND: ins_pos = '0;
            default:     ins_pos = pos_cmp;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        status_next = status_reg;
        elem_next   = elem_reg;
        index_next  = index_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = ptr_reg;
        push        = 1'b0;
        word        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = command;
                    val_next    = value;
                    status_next = ST_OK;
                    elem_next   = '0;
                    index_next  = '0;
                    ptr_next    = '0;
                    state_next  = S_EMIT;
                    case (command)
                        CMD_APPEND, CMD_PREPEND, CMD_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (ins_pos > cnt_cmp)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                pos_next   = AW'(ins_pos);
                                ptr_next   = AW'(cnt_reg);
                                state_next = (ins_pos == cnt_cmp) ? S_INS_WR : S_SHF_RD;
                            end
                        end
                        CMD_REM_VAL, CMD_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        CMD_REM_AT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_cmp >= cnt_cmp)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ptr_next = AW'(position);
                                // tail element: nothing to shift, just drop it
                                if (pos_cmp + CMP_W'(1) == cnt_cmp)
                                begin
                                    cnt_next = CW'(cnt_reg - CW'(1));
                                end
                                else
                                begin
                                    state_next = S_DEL_RD;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        CMD_SIZE:
                        begin
                            index_next = IDX_W'(cnt_reg);
                        end
                        CMD_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DMP_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata == val_reg)
                begin
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        elem_next  = ram_rdata;
                        index_next = IDX_W'(ptr_reg);
                        state_next = S_EMIT;
                    end
                    else if (ptr_at_end)
                    begin
                        cnt_next   = CW'(cnt_reg - CW'(1));
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // close the gap from the match onward
                        state_next = S_DEL_RD;
                    end
                end
                else if (ptr_at_end)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_EMIT;
                end
                else
                begin
                    ptr_next   = AW'(ptr_reg + AW'(1));
                    state_next = S_SCAN_RD;
                end
            end
            S_SHF_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(ptr_reg - AW'(1));
                state_next = S_SHF_WR;
            end
            S_SHF_WR:
            begin
                // move one entry up, walking down toward the insert slot
                ram_we     = 1'b1;
                ptr_next   = AW'(ptr_reg - AW'(1));
                state_next = (AW'(ptr_reg - AW'(1)) == pos_reg) ? S_INS_WR : S_SHF_RD;
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                cnt_next   = CW'(cnt_reg + CW'(1));
                state_next = S_EMIT;
            end
            S_DEL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(ptr_reg + AW'(1));
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                // move one entry down, walking up toward the tail
                ram_we   = 1'b1;
                ptr_next = AW'(ptr_reg + AW'(1));
                if ((CW'(ptr_reg) + CW'(2)) == cnt_reg)
                begin
                    cnt_next   = CW'(cnt_reg - CW'(1));
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_DEL_RD;
                end
            end
            S_DMP_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_DMP_OUT;
            end
            S_DMP_OUT:
            begin
                // read data holds until the slot frees up
                if (slot_free)
                begin
                    push         = 1'b1;
                    word.status  = ST_OK;
                    word.element = ram_rdata;
                    word.index   = IDX_W'(ptr_reg);
                    word.last    = ptr_at_end;
                    if (ptr_at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = AW'(ptr_reg + AW'(1));
                        state_next = S_DMP_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    push         = 1'b1;
                    word.status  = status_reg;
                    word.element = elem_reg;
                    word.index   = index_reg;
                    word.last    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        elem_reg   <= elem_next;
        index_reg  <= index_next;
    end

endmodule

### rtl/core/ordered_list_engine_unit.sv
// Ordered list engine: bounded list of signed 32-bit values held in one RAM.
// Depends on olst_pkg, olst_ram, olst_ctrl and olst_out_reg.
//
// One command is in work at a time; cmd_stall stays high until its last
// result word has been loaded into the output register. Every RAM access of
// a walk is a read followed by a write or a compare in the next cycle, so the
// single registered read port sets the pace of every walk. Commands that need
// no walk are accepted and then give their result; append writes its element
// in between. Insert at position p shifts the entries from p to the tail up
// one place, remove at p shifts those above p down, a search or remove by
// value scans until a match (a remove then shifts the rest down), and a dump
// reads out every element; all are stretched by any stall on the result
// channel. The longest command is a remove by value or a failed search on a
// full list.
// Elements are not cleared at reset; only entries below the count are read.
module ordered_list_engine_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [olst_pkg::CMD_W-1:0]    command,
    input  logic signed [olst_pkg::VAL_W-1:0] value,
    input  logic [olst_pkg::POS_W-1:0]    position,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [olst_pkg::ST_W-1:0]     status,
    output logic signed [olst_pkg::VAL_W-1:0] element,
    output logic [olst_pkg::IDX_W-1:0]    index,
    output logic                          last
);
    import olst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic             push;
    olst_word_t       word;
    logic             slot_free;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    olst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    olst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .value     (value),
        .position  (position),
        .push      (push),
        .word      (word),
        .slot_free (slot_free),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    olst_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .word      (word),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .element   (element),
        .index     (index),
        .last      (last)
    );

endmodule

### rtl/core/olst_checker.sv
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on olst_pkg and ordered_list_engine_unit.
module olst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_stall,
    input logic [olst_pkg::CMD_W-1:0]    command,
    input logic signed [olst_pkg::VAL_W-1:0] value,
    input logic [olst_pkg::POS_W-1:0]    position,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [olst_pkg::ST_W-1:0]     status,
    input logic signed [olst_pkg::VAL_W-1:0] element,
    input logic [olst_pkg::IDX_W-1:0]    index,
    input logic                          last
);
    import olst_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(element)
            && $stable(index) && $stable(last))
    else $error("result word changed while stalled");

    // one command at a time: an accepted word blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted back to back");

    // only dump produces words before the last, and those are all ok
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> status == ST_OK)
    else $error("non-final result word with error status");

    // an error status always ends the command
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> last)
    else $error("error status without last mark");

endmodule

bind ordered_list_engine_unit olst_checker u_olst_checker (.*);

### tb/tb_ordered_list_engine_unit.sv
// Self-checking testbench for ordered_list_engine_unit: directed and random list commands
// are checked word by word against a behavioral list model kept in the bench.
// Depends on olst_pkg and the ordered_list_engine_unit RTL.
module tb_ordered_list_engine_unit;
    import olst_pkg::*;

    localparam int CAP         = 32;
    localparam int RAND_ITEMS  = 220;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [VAL_W-1:0]  val;
        logic [POS_W-1:0]         pos;
        bit                       drain;
        bit                       choke;
        int                       words;
        int                       gap;
    } cmd_item_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cmd_valid = 1'b0;
    logic                     cmd_stall;
    logic [CMD_W-1:0]         command   = '0;
    logic signed [VAL_W-1:0]  value     = '0;
    logic [POS_W-1:0]         position  = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [ST_W-1:0]          status;
    logic signed [VAL_W-1:0]  element;
    logic [IDX_W-1:0]         index;
    logic                     last;

    // list model
    logic signed [VAL_W-1:0]  list_store [CAP];
    int                       list_len;

    cmd_item_t   cmd_backlog [$];
    olst_word_t  due_words [$];

    int  cycle         = 0;
    int  err_count     = 0;
    int  cmd_words_due = 0;
    int  words_seen    = 0;
    int  long_left     = 0;
    bit  choke_req     = 1'b0;
    // driver and monitor private state
    bit  gap_armed;
    int  gap_left;
    int  cur_words;
    int  hold_left;

    ordered_list_engine_unit #(
        .CAPACITY (CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .command   (command),
        .value     (value),
        .position  (position),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .element   (element),
        .index     (index),
        .last      (last)
    );

    always #4 clk = ~clk;

    task automatic report(input string what);
        err_count++;
        if (err_count <= 40)
        begin
            $display("ERROR cycle %0d: %s", cycle, what);
        end
    endtask

    function automatic logic [ST_W-1:0] place(input int at, input logic signed [VAL_W-1:0] v);
        int k;
        if (list_len >= CAP)
        begin
            return ST_FULL;
        end
        if (at > list_len)
        begin
            return ST_BADPOS;
        end
        for (k = list_len; k > at; k--)
        begin
            list_store[k] = list_store[k-1];
        end
        list_store[at] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic void drop(input int at);
        int k;
        for (k = at; k + 1 < list_len; k++)
        begin
            list_store[k] = list_store[k+1];
        end
        list_len--;
    endfunction

    function automatic int locate(input logic signed [VAL_W-1:0] v);
        int k;
        for (k = 0; k < list_len; k++)
        begin
            if (list_store[k] == v)
            begin
                return k;
            end
        end
        return -1;
    endfunction

    // Apply one command to the list model and queue the result words it gives.
    task automatic list_apply(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] v,
                              input logic [POS_W-1:0] p, output int n);
        logic [ST_W-1:0]         st;
        logic signed [VAL_W-1:0] el;
        logic [IDX_W-1:0]        ix;
        int                      k;
        st = ST_OK;
        el = '0;
        ix = '0;
        n  = 1;
        case (c)
            CMD_APPEND:  st = place(list_len, v);
            CMD_PREPEND: st = place(0, v);
            CMD_INSERT:  st = place(int'(p), v);
            CMD_REM_VAL:
            begin
                k = locate(v);
                if (list_len == 0)
                    st = ST_EMPTY;
                else if (k < 0)
                    st = ST_NOTFOUND;
                else
                    drop(k);
            end
            CMD_REM_AT:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else if (int'(p) >= list_len)
                    st = ST_BADPOS;
                else
                    drop(int'(p));
            end
            CMD_SEARCH:
            begin
                k = locate(v);
                if (list_len == 0)
                    st = ST_EMPTY;
                else if (k < 0)
                    st = ST_NOTFOUND;
                else
                begin
                    el = list_store[k];
                    ix = IDX_W'(k);
                end
            end
            CMD_CLEAR:   list_len = 0;
            CMD_SIZE:    ix = IDX_W'(list_len);
            CMD_DUMP:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else
                    n = list_len;
            end
            default: ;
        endcase
        if (c == CMD_DUMP && list_len > 0)
        begin
            for (k = 0; k < list_len; k++)
            begin
                due_words.push_back('{ST_OK, list_store[k], IDX_W'(k), k == list_len - 1});
            end
        end
        else
        begin
            due_words.push_back('{st, el, ix, 1'b1});
        end
    endtask

    task automatic add(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] v,
                       input logic [POS_W-1:0] p, input bit drain, input bit choke);
        cmd_item_t it;
        int        n;
        list_apply(c, v, p, n);
        it.cmd   = c;
        it.val   = v;
        it.pos   = p;
        it.drain = drain;
        it.choke = choke;
        it.words = n;
        // every third block of 30 items goes back to back
        it.gap   = (((cmd_backlog.size() / 30) % 3) == 1) ? 0 : $urandom_range(0, 11);
        cmd_backlog.push_back(it);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_val();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = (list_len > 0) ? list_store[$urandom_range(0, list_len - 1)] : 32'sd0;
            2: v = $signed($urandom_range(0, 15)) - 8;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Command side: one word in flight, gap drawn per item, drain items wait for all results.
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit        taken;
        bit        launch;
        bit        choke_now;
        cmd_item_t it;
        if (!rst_n)
        begin
            cmd_valid     <= 1'b0;
            command       <= '0;
            value         <= '0;
            position      <= '0;
            cmd_words_due <= 0;
            choke_req     <= 1'b0;
            gap_armed = 1'b0;
            gap_left  = 0;
            cur_words = 0;
        end
        else
        begin
            taken     = cmd_valid && !cmd_stall;
            launch    = 1'b0;
            choke_now = 1'b0;
            if (!cmd_valid || taken)
            begin
                if (!gap_armed && cmd_backlog.size() > 0)
                begin
                    gap_left  = cmd_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_armed)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else if (!cmd_backlog[0].drain ||
                             words_seen == cmd_words_due + (taken ? cur_words : 0))
                        launch = 1'b1;
                end
            end
            if (taken)
                cmd_words_due <= cmd_words_due + cur_words;
            if (launch)
            begin
                it        = cmd_backlog.pop_front();
                gap_armed = 1'b0;
                command   <= it.cmd;
                value     <= it.val;
                position  <= it.pos;
                cmd_valid <= 1'b1;
                cur_words = it.words;
                choke_now = it.choke;
            end
            else if (taken)
            begin
                cmd_valid <= 1'b0;
            end
            choke_req <= choke_now;
        end
    end

    // Long receiver hold-off, started by a marked command.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_left <= 0;
        else if (choke_req)
            long_left <= LONG_HOLD;
        else if (long_left > 0)
            long_left <= long_left - 1;
    end

    // Result side: check each accepted word, then draw the stall before the next one.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        olst_word_t w;
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            words_seen <= 0;
            hold_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (due_words.size() == 0)
                begin
                    report($sformatf("word %0d unexpected: status=%0d element=%0d index=%0d",
                                     words_seen, status, element, index));
                end
                else
                begin
                    w = due_words.pop_front();
                    if (status !== w.status)
                        report($sformatf("word %0d status %0d, want %0d",
                                         words_seen, status, w.status));
                    if (element !== w.element)
                        report($sformatf("word %0d element %0d, want %0d",
                                         words_seen, element, w.element));
                    if (index !== w.index)
                        report($sformatf("word %0d index %0d, want %0d",
                                         words_seen, index, w.index));
                    if (last !== w.last)
                        report($sformatf("word %0d last %0d, want %0d",
                                         words_seen, last, w.last));
                end
                words_seen <= words_seen + 1;
                hold_left = (((words_seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 11);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            res_stall <= (hold_left > 0) || (long_left > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int                      i;
        int                      r;
        int                      k;
        int                      ins_w;
        bit                      draining;
        logic [CMD_W-1:0]        c;
        logic [POS_W-1:0]        p;
        logic signed [VAL_W-1:0] v;

        list_len = 0;

        // empty list cases
        add(CMD_SIZE,    0, 0, 0, 0);
        add(CMD_DUMP,    0, 0, 0, 0);
        add(CMD_SEARCH,  5, 0, 0, 0);
        add(CMD_REM_VAL, 5, 0, 0, 0);
        add(CMD_REM_AT,  0, 0, 0, 0);
        // value extremes, insert at the end, past the end
        add(CMD_APPEND,  32'sh7FFF_FFFF, 0, 0, 0);
        add(CMD_PREPEND, 32'sh8000_0000, 0, 0, 0);
        add(CMD_INSERT,  0, 2, 0, 0);
        add(CMD_INSERT,  7, 4, 0, 0);
        add(CMD_INSERT,  7, 63, 0, 0);
        add(CMD_INSERT,  -1, 1, 0, 0);
        // search hits the final element
        add(CMD_SEARCH,  0, 0, 0, 0);
        add(CMD_SEARCH,  12345, 0, 0, 0);
        add(CMD_REM_VAL, 12345, 0, 0, 0);
        add(CMD_REM_AT,  0, 63, 0, 0);
        add(CMD_REM_AT,  0, 4, 0, 0);
        // unused opcodes
        add(CMD_W'(9),  -1, 63, 0, 0);
        add(CMD_W'(15), 32'sh8000_0000, 0, 0, 0);
        add(CMD_DUMP,    0, 0, 0, 0);
        add(CMD_REM_VAL, 32'sh8000_0000, 0, 1, 0);
        add(CMD_REM_AT,  0, 2, 0, 0);
        add(CMD_SIZE,    0, 0, 0, 0);
        add(CMD_CLEAR,   0, 0, 0, 0);
        add(CMD_SIZE,    0, 0, 0, 0);

        // random: alternate filling and draining phases, with some noise
        draining = 1'b0;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (list_len == CAP && $urandom_range(0, 2) == 0)
                draining = 1'b1;
            if (list_len == 0)
                draining = 1'b0;
            ins_w = draining ? 15 : 60;
            r = $urandom_range(0, 99);
            v = pick_val();
            p = ($urandom_range(0, 7) == 0) ? POS_W'($urandom_range(0, 63))
                                             : POS_W'($urandom_range(0, list_len));
            if (r < 8)
            begin
                c = CMD_W'($urandom_range(0, 15));
                v = $urandom;
                p = POS_W'($urandom_range(0, 63));
            end
            else if (r < 15)
                c = CMD_DUMP;
            else if (r < 20)
                c = CMD_SIZE;
            else if (r < 22)
                c = CMD_CLEAR;
            else if (r < 22 + ins_w)
            begin
                k = $urandom_range(0, 2);
                c = (k == 0) ? CMD_APPEND : (k == 1) ? CMD_PREPEND : CMD_INSERT;
            end
            else
            begin
                k = $urandom_range(0, 2);
                c = (k == 0) ? CMD_REM_VAL : (k == 1) ? CMD_REM_AT : CMD_SEARCH;
            end
            add(c, v, p, (i % 60) == 30, 1'b0);
        end

        // fill to capacity, hit every refused insert, then hold off the result side
        while (list_len < CAP)
        begin
            add(CMD_APPEND, pick_val(), 0, 0, 0);
        end
        add(CMD_APPEND,  1, 0, 0, 0);
        add(CMD_PREPEND, 2, 0, 0, 0);
        add(CMD_INSERT,  3, 63, 0, 0);
        add(CMD_SIZE,    0, 0, 0, 0);
        add(CMD_DUMP,    0, 0, 0, 1);
        add(CMD_SEARCH,  list_store[CAP-1], 0, 0, 0);
        add(CMD_REM_AT,  0, 0, 0, 0);
        add(CMD_SIZE,    0, 0, 0, 0);
        add(CMD_DUMP,    0, 0, 0, 0);
        add(CMD_CLEAR,   0, 0, 1, 0);
        add(CMD_DUMP,    0, 0, 0, 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() > 0 || cmd_valid || due_words.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4 * CAP + 16) @(posedge clk);
        if (due_words.size() != 0)
            report($sformatf("%0d result words never arrived", due_words.size()));

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
